FILE: sv/cfir_pkg.sv
// Shared types and constants for the complex FIR filter unit.
// Used by cfir_cell and complex_fir_filter_unit; depends on nothing.
`default_nettype none

package cfir_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 18;
  localparam int COEF_IDX_W = 6;
  localparam int OUT_W      = 24;
  localparam int PROD_W     = SAMPLE_W + COEF_W;

  localparam int OUT_MAX = 8388607;
  localparam int OUT_MIN = -8388608;

  // item kind codes
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] q;
    logic signed [SAMPLE_W-1:0] i;
  } sample_t;

  typedef struct packed {
    logic                     shift;
    logic                     coef_wr;
    logic signed [COEF_W-1:0] coef;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/complex_fir_filter_unit.sv
// Complex FIR filter with real tap weights: a chain of TAPS cells plus control.
// Depends on cfir_pkg and cfir_cell.
//
// A sample beat shifts the new complex sample into the delay chain; its result
// beat is registered once the partial sums have travelled through every cell
// (one cell per cycle), and the next beat is taken once that result sits in
// the output register. A coefficient beat writes one tap weight and gives no
// result; an index of TAPS or above is dropped. Each sum is rounded (add one
// half, floor) and clipped to 24 bits, with saturated_o set when either part
// was clipped. Delay line and weights reset to zero.
`default_nettype none

module complex_fir_filter_unit #(
  parameter int TAPS = 33
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    in_valid_i,
  output logic                                   in_ready_o,
  input  wire                                    kind_i,
  input  wire  signed [cfir_pkg::SAMPLE_W-1:0]   sample_i_i,
  input  wire  signed [cfir_pkg::SAMPLE_W-1:0]   sample_q_i,
  input  wire         [cfir_pkg::COEF_IDX_W-1:0] coef_index_i,
  input  wire  signed [cfir_pkg::COEF_W-1:0]     coef_value_i,
  output logic                                   out_valid_o,
  input  wire                                    out_ready_i,
  output logic signed [cfir_pkg::OUT_W-1:0]      out_i_o,
  output logic signed [cfir_pkg::OUT_W-1:0]      out_q_o,
  output logic                                   saturated_o
);

  localparam int ACC_W = cfir_pkg::PROD_W + 7 + $clog2(TAPS);
  localparam int QW    = ACC_W - 16;
  localparam int CNT_W = $clog2(TAPS + 2);
  localparam logic [CNT_W-1:0]      CNT_DONE = CNT_W'(TAPS + 1);
  localparam logic signed [ACC_W-1:0] RND    = ACC_W'(32768);
  localparam logic signed [QW-1:0]  Q_MAX    = QW'(cfir_pkg::OUT_MAX);
  localparam logic signed [QW-1:0]  Q_MIN    = QW'(cfir_pkg::OUT_MIN);

  cfir_pkg::sample_t          samp_chain [0:TAPS];
  logic signed [ACC_W-1:0]    sum_i_chain [0:TAPS];
  logic signed [ACC_W-1:0]    sum_q_chain [0:TAPS];

  logic             accept, take_sample, take_coef, fin, load;
  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic [cfir_pkg::OUT_W:0] rc_i, rc_q;

  function automatic logic [cfir_pkg::OUT_W:0] round_clip(logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] t;
    logic signed [QW-1:0]    q;
    logic [cfir_pkg::OUT_W:0] r;
    t = a + RND;
    q = t[ACC_W-1:16];
    if (q > Q_MAX) begin
      r = {1'b1, cfir_pkg::OUT_W'(Q_MAX)};
    end else if (q < Q_MIN) begin
      r = {1'b1, cfir_pkg::OUT_W'(Q_MIN)};
    end else begin
      r = {1'b0, q[cfir_pkg::OUT_W-1:0]};
    end
    return r;
  endfunction

  assign in_ready_o  = !busy_q;
  assign accept      = in_valid_i && in_ready_o;
  assign take_sample = accept && (kind_i == cfir_pkg::KIND_SAMPLE);
  assign take_coef   = accept && (kind_i == cfir_pkg::KIND_COEF);

  assign samp_chain[0]  = '{q: sample_q_i, i: sample_i_i};
  assign sum_i_chain[0] = '0;
  assign sum_q_chain[0] = '0;

  for (genvar k = 0; k < TAPS; k++) begin : g_tap
    cfir_pkg::cell_ctrl_t ctrl;
    assign ctrl.shift   = take_sample;
    assign ctrl.coef_wr = take_coef && (32'(coef_index_i) == k);
    assign ctrl.coef    = coef_value_i;

    cfir_cell #(
      .ACC_W(ACC_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .samp_i  (samp_chain[k]),
      .samp_o  (samp_chain[k+1]),
      .sum_i_i (sum_i_chain[k]),
      .sum_q_i (sum_q_chain[k]),
      .sum_i_o (sum_i_chain[k+1]),
      .sum_q_o (sum_q_chain[k+1])
    );
  end

  // the last cell's sums are settled once the count reaches TAPS+1
  assign fin  = busy_q && (cnt_q == CNT_DONE);
  assign load = fin && (!out_valid_q || out_ready_i);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (take_sample) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (load) begin
      busy_d = 1'b0;
    end else if (busy_q && !fin) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign rc_i = round_clip(sum_i_chain[TAPS]);
  assign rc_q = round_clip(sum_q_chain[TAPS]);

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_i_o     <= rc_i[cfir_pkg::OUT_W-1:0];
      out_q_o     <= rc_q[cfir_pkg::OUT_W-1:0];
      saturated_o <= rc_i[cfir_pkg::OUT_W] | rc_q[cfir_pkg::OUT_W];
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_sample_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_sample |=> !in_ready_o)
    else $error("input taken while a sample is still in the chain");

  a_result_from_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_o && !busy_q)
    else $error("result load did not present a beat and free the chain");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q <= CNT_DONE)
    else $error("sum travel count ran past the end of the chain");

  a_coef_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_coef && !out_valid_o |=> !out_valid_o)
    else $error("coefficient beat produced a result");
`endif

endmodule

`default_nettype wire

FILE: sv/cfir_cell.sv
// One tap of the filter chain: delay stage, tap weight, product and partial sums.
// Depends on cfir_pkg for the sample and control types.
`default_nettype none

module cfir_cell #(
  parameter int ACC_W = 41
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire  cfir_pkg::cell_ctrl_t  ctrl_i,
  input  wire  cfir_pkg::sample_t     samp_i,
  output cfir_pkg::sample_t           samp_o,
  input  wire  signed [ACC_W-1:0]     sum_i_i,
  input  wire  signed [ACC_W-1:0]     sum_q_i,
  output logic signed [ACC_W-1:0]     sum_i_o,
  output logic signed [ACC_W-1:0]     sum_q_o
);

  cfir_pkg::sample_t                     samp_q;
  logic signed [cfir_pkg::COEF_W-1:0]    weight_q;
  logic signed [cfir_pkg::PROD_W-1:0]    prod_i_d, prod_q_d;
  logic signed [cfir_pkg::PROD_W-1:0]    prod_i_q, prod_q_q;
  logic signed [ACC_W-1:0]               acc_i_q, acc_q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samp_q   <= '0;
      weight_q <= '0;
    end else begin
      if (ctrl_i.shift) begin
        samp_q <= samp_i;
      end
      if (ctrl_i.coef_wr) begin
        weight_q <= ctrl_i.coef;
      end
    end
  end

  assign prod_i_d = weight_q * samp_q.i;
  assign prod_q_d = weight_q * samp_q.q;

  // products and partial sums run freely; the controller picks the settled sum
  always_ff @(posedge clk_i) begin
    prod_i_q <= prod_i_d;
    prod_q_q <= prod_q_d;
    acc_i_q  <= sum_i_i + ACC_W'(prod_i_q);
    acc_q_q  <= sum_q_i + ACC_W'(prod_q_q);
  end

  assign samp_o  = samp_q;
  assign sum_i_o = acc_i_q;
  assign sum_q_o = acc_q_q;

endmodule

`default_nettype wire

FILE: test/complex_fir_filter_unit_tb.sv
// Self-checking testbench for complex_fir_filter_unit: directed and random beats,
// checked against an in-bench predictor of the rounded, clipped tap sums.
// Depends on cfir_pkg and the RTL of complex_fir_filter_unit.
`default_nettype none

module complex_fir_filter_unit_tb;

  localparam int TAPS         = 33;
  localparam int MAX_GAP      = 14;
  localparam int DRAIN_CYCLES = TAPS + 8;
  localparam int RAND_PHASES  = 4;
  localparam int PHASE_MIXED  = 200;

  localparam int SAMPLE_W   = cfir_pkg::SAMPLE_W;
  localparam int COEF_W     = cfir_pkg::COEF_W;
  localparam int COEF_IDX_W = cfir_pkg::COEF_IDX_W;
  localparam int OUT_W      = cfir_pkg::OUT_W;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;
  localparam logic signed [COEF_W-1:0]   W_MAX = 18'sh1ffff;
  localparam logic signed [COEF_W-1:0]   W_MIN = 18'sh20000;

  typedef struct packed {
    logic signed [OUT_W-1:0] out_re;
    logic signed [OUT_W-1:0] out_im;
    logic                    sat;
  } filter_out_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic                         kind_i;
  logic signed [SAMPLE_W-1:0]   sample_i_i;
  logic signed [SAMPLE_W-1:0]   sample_q_i;
  logic        [COEF_IDX_W-1:0] coef_index_i;
  logic signed [COEF_W-1:0]     coef_value_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic signed [OUT_W-1:0]      out_i_o;
  logic signed [OUT_W-1:0]      out_q_o;
  logic                         saturated_o;

  // predictor state
  logic signed [COEF_W-1:0]   tap_w  [TAPS];
  logic signed [SAMPLE_W-1:0] hist_i [TAPS];
  logic signed [SAMPLE_W-1:0] hist_q [TAPS];

  filter_out_t pending_outputs[$];

  bit no_idle;
  int fail_count;
  int samples_sent;
  int coefs_sent;
  int outputs_checked;

  complex_fir_filter_unit #(
    .TAPS(TAPS)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .sample_i_i  (sample_i_i),
    .sample_q_i  (sample_q_i),
    .coef_index_i(coef_index_i),
    .coef_value_i(coef_value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_i_o     (out_i_o),
    .out_q_o     (out_q_o),
    .saturated_o (saturated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // round half up by floor shift, then clip to the output width
  function automatic logic signed [OUT_W-1:0] round_clip(input longint acc,
                                                         output logic clipped);
    longint q;
    q       = (acc + 64'sd32768) >>> 16;
    clipped = 1'b0;
    if (q > cfir_pkg::OUT_MAX) begin
      clipped = 1'b1;
      return OUT_W'(cfir_pkg::OUT_MAX);
    end
    if (q < cfir_pkg::OUT_MIN) begin
      clipped = 1'b1;
      return OUT_W'(cfir_pkg::OUT_MIN);
    end
    return q[OUT_W-1:0];
  endfunction

  function automatic filter_out_t filter_sample(input logic signed [SAMPLE_W-1:0] si,
                                                input logic signed [SAMPLE_W-1:0] sq);
    longint      acc_i;
    longint      acc_q;
    logic        clip_i;
    logic        clip_q;
    filter_out_t res;
    acc_i = 0;
    acc_q = 0;
    for (int k = TAPS - 1; k > 0; k--) begin
      hist_i[k] = hist_i[k-1];
      hist_q[k] = hist_q[k-1];
    end
    hist_i[0] = si;
    hist_q[0] = sq;
    for (int k = 0; k < TAPS; k++) begin
      acc_i += longint'(tap_w[k]) * longint'(hist_i[k]);
      acc_q += longint'(tap_w[k]) * longint'(hist_q[k]);
    end
    res.out_re = round_clip(acc_i, clip_i);
    res.out_im = round_clip(acc_q, clip_q);
    res.sat    = clip_i | clip_q;
    return res;
  endfunction

  // Offer one beat; returns at the edge where it was taken.
  task automatic send_beat(input logic                         kind,
                           input logic signed [SAMPLE_W-1:0]   si,
                           input logic signed [SAMPLE_W-1:0]   sq,
                           input logic        [COEF_IDX_W-1:0] idx,
                           input logic signed [COEF_W-1:0]     val);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    sample_i_i   <= si;
    sample_q_i   <= sq;
    coef_index_i <= idx;
    coef_value_i <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (kind == cfir_pkg::KIND_COEF) begin
      coefs_sent++;
      if (idx < TAPS) tap_w[idx] = val;
    end else begin
      samples_sent++;
      pending_outputs.push_back(filter_sample(si, sq));
    end
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] si,
                             input logic signed [SAMPLE_W-1:0] sq);
    send_beat(cfir_pkg::KIND_SAMPLE, si, sq, COEF_IDX_W'($urandom), COEF_W'($urandom));
  endtask

  task automatic send_coef(input logic [COEF_IDX_W-1:0] idx,
                           input logic signed [COEF_W-1:0] val);
    send_beat(cfir_pkg::KIND_COEF, SAMPLE_W'($urandom), SAMPLE_W'($urandom), idx, val);
  endtask

  // hold the input side until every result is back
  task automatic drain_outputs();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_outputs.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int pct_extreme);
    if ($urandom_range(0, 99) < pct_extreme) begin
      case ($urandom_range(0, 3))
        0:       return S_MAX;
        1:       return S_MIN;
        2:       return '0;
        default: return '1;
      endcase
    end
    return SAMPLE_W'($urandom);
  endfunction

  function automatic logic signed [COEF_W-1:0] pick_weight(input int style, input int k);
    case (style)
      0:       return COEF_W'($urandom);
      1:       return W_MIN;
      2:       return k[0] ? W_MAX : W_MIN;
      default: return COEF_W'($urandom_range(0, 4095)) - COEF_W'(2048);
    endcase
  endfunction

  task automatic test_zero_weights();
    send_sample(S_MAX, S_MIN);
    send_sample(S_MIN, S_MAX);
    send_sample('0, '0);
  endtask

  task automatic test_coef_extremes();
    send_coef('0, W_MAX);
    send_coef(COEF_IDX_W'(1), W_MIN);
    send_coef(COEF_IDX_W'(TAPS - 1), W_MIN);
    // out of range taps: drop the write
    send_coef(COEF_IDX_W'(TAPS), 18'sd5000);
    send_coef('1, '1);
    send_sample(S_MAX, S_MIN);
    send_sample(S_MIN, S_MAX);
    send_sample(S_MIN, S_MIN);
    send_sample('1, 16'sd1);
  endtask

  task automatic test_unused_fields();
    send_beat(cfir_pkg::KIND_COEF, S_MIN, '1, COEF_IDX_W'(2), 18'sd65536);
    send_beat(cfir_pkg::KIND_COEF, '1, S_MAX, COEF_IDX_W'(3), '0);
    send_beat(cfir_pkg::KIND_SAMPLE, 16'sd12345, -16'sd4321, '1, W_MIN);
    send_beat(cfir_pkg::KIND_SAMPLE, -16'sd1, 16'sd77, '0, W_MAX);
  endtask

  task automatic test_pause_until_empty();
    send_coef('0, -18'sd65536);
    send_sample(16'sd1000, -16'sd1000);
    drain_outputs();
    send_sample(S_MAX, S_MAX);
  endtask

  task automatic test_random_traffic();
    int pct;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      no_idle = (ph == 2);
      pct     = (ph == 1) ? 60 : 15;
      for (int k = 0; k < TAPS; k++) send_coef(COEF_IDX_W'(k), pick_weight(ph, k));
      for (int n = 0; n < PHASE_MIXED; n++) begin
        if ($urandom_range(0, 99) < 12) begin
          if ($urandom_range(0, 3) == 0)
            send_coef(COEF_IDX_W'($urandom_range(TAPS, 63)), COEF_W'($urandom));
          else
            send_coef(COEF_IDX_W'($urandom_range(0, TAPS - 1)), pick_weight(ph, n));
        end else begin
          send_sample(pick_sample(pct), pick_sample(pct));
        end
        if ($urandom_range(0, 99) == 0) drain_outputs();
      end
    end
    no_idle = 1'b0;
  endtask

  // result side: sometimes stall after a result shows, then take and check it
  initial begin
    int          stall;
    filter_out_t exp_out;
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        @(posedge clk_i);
        while (!out_valid_o) @(posedge clk_i);
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      if (pending_outputs.size() == 0) begin
        $error("output beat with no result outstanding: out_i %0d out_q %0d",
               out_i_o, out_q_o);
        fail_count++;
      end else begin
        exp_out = pending_outputs.pop_front();
        outputs_checked++;
        if (out_i_o !== exp_out.out_re) begin
          $error("out_i: expected %0d, got %0d", exp_out.out_re, out_i_o);
          fail_count++;
        end
        if (out_q_o !== exp_out.out_im) begin
          $error("out_q: expected %0d, got %0d", exp_out.out_im, out_q_o);
          fail_count++;
        end
        if (saturated_o !== exp_out.sat) begin
          $error("saturated: expected %0b, got %0b", exp_out.sat, saturated_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", pending_outputs.size());
    $display("complex_fir_filter_unit_tb NOT OK");
    $finish;
  end

  initial begin
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    kind_i       <= cfir_pkg::KIND_SAMPLE;
    sample_i_i   <= '0;
    sample_q_i   <= '0;
    coef_index_i <= '0;
    coef_value_i <= '0;
    no_idle         = 1'b0;
    fail_count      = 0;
    samples_sent    = 0;
    coefs_sent      = 0;
    outputs_checked = 0;
    for (int k = 0; k < TAPS; k++) begin
      tap_w[k]  = '0;
      hist_i[k] = '0;
      hist_q[k] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_weights();
    test_coef_extremes();
    test_unused_fields();
    test_pause_until_empty();
    test_random_traffic();

    in_valid_i <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d sample beats and %0d coefficient beats (in and out of range),",
             samples_sent, coefs_sent);
    $display("with %0d filter outputs compared, including full-scale tap sets", outputs_checked);
    if (fail_count == 0) begin
      $display("complex_fir_filter_unit_tb OK");
    end else begin
      $display("complex_fir_filter_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
